FILE: src/hcfp_pkg.sv
// Shared types, character codes and the hex digit decoder of the
// hex coordinate frame parser. No dependencies.
package hcfp_pkg;

  localparam int unsigned FRAME_DIGITS = 8;
  localparam int unsigned COUNT_W      = $clog2(FRAME_DIGITS);
  localparam int unsigned LIMIT_W      = 15;

  localparam logic [7:0]         CHAR_STOP    = 8'h6E;
  localparam logic [7:0]         CHAR_NEWLINE = 8'h0A;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 15'd255;

  // Result kind codes
  typedef enum logic [1:0] {
    KIND_ACCEPTED     = 2'd0,
    KIND_OUT_OF_RANGE = 2'd1,
    KIND_STOP         = 2'd2
  } frame_kind_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_digit_t;

  // Decode an upper-case hex character; ok is low for any other byte
  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t d;
    d.ok    = 1'b0;
    d.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d.ok    = 1'b1;
      d.value = c[3:0];
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d.ok    = 1'b1;
      d.value = 4'(c[3:0] + 4'd9);
    end
    return d;
  endfunction

endpackage

FILE: src/hex_coordinate_frame_parser.sv
// Top level of the hex coordinate frame parser: input byte register,
// frame decode and range check, result register. Depends on hcfp_pkg.
//
//  channel   dir  handshake             payload
//  in        in   in_valid / in_ready   rx_byte[7:0]
//  out       out  out_valid / out_ready pos_x[15:0], pos_y[15:0], frame_kind[1:0]
//  cfg       in   cfg_valid / cfg_ready position_limit[14:0]
//
// One byte per cycle while the result register can move: an accepted byte sits
// in the input register, is decoded against the digit store and counter, and
// moves into the result register once that register can move, so a frame's
// closing byte passes through the input register and then the result register.
// Synchronous active-high reset clears the counter, the limit (to 255) and
// both valid flags. A stalled result holds the result register; the input
// register takes a byte while it is empty or while the result register can move.
module hex_coordinate_frame_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] pos_x,
  output logic [15:0] pos_y,
  output logic [1:0]  frame_kind,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [14:0] position_limit
);

  logic [hcfp_pkg::LIMIT_W-1:0] limit;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       out_free;
  logic       s1_advance;

  logic [hcfp_pkg::COUNT_W-1:0] digit_count;
  logic [hcfp_pkg::COUNT_W-1:0] digit_count_next;
  logic [3:0]                   digit_store [hcfp_pkg::FRAME_DIGITS-1];
  logic                         store_we;

  hcfp_pkg::hex_digit_t  hv;
  logic                  emit;
  hcfp_pkg::frame_kind_t kind_next;
  logic [15:0]           pos_x_next;
  logic [15:0]           pos_y_next;
  logic [15:0]           wx;
  logic [15:0]           wy;
  logic signed [16:0]    lim_pos;
  logic signed [16:0]    lim_neg;
  logic                  x_in;
  logic                  y_in;

  hcfp_pkg::frame_kind_t kind;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= hcfp_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit <= position_limit;
    end
  end

  // Input byte register
  assign out_free   = !out_valid || out_ready;
  assign s1_advance = s1_valid && out_free;
  assign in_ready   = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= rx_byte;
    end
  end

  // Assemble both words; the eighth digit comes straight from the byte
  assign hv = hcfp_pkg::hex_decode(s1_byte);
  assign wx = {digit_store[0], digit_store[1], digit_store[2], digit_store[3]};
  assign wy = {digit_store[4], digit_store[5], digit_store[6], hv.value};

  // Range check against plus or minus the limit
  assign lim_pos = signed'({2'b00, limit});
  assign lim_neg = -lim_pos;
  assign x_in = (signed'({wx[15], wx}) >= lim_neg) && (signed'({wx[15], wx}) <= lim_pos);
  assign y_in = (signed'({wy[15], wy}) >= lim_neg) && (signed'({wy[15], wy}) <= lim_pos);

  // Per-byte decision
  always_comb begin
    emit             = 1'b0;
    store_we         = 1'b0;
    kind_next        = hcfp_pkg::KIND_STOP;
    pos_x_next       = '0;
    pos_y_next       = '0;
    digit_count_next = digit_count;
    if (digit_count == '0 && s1_byte == hcfp_pkg::CHAR_STOP) begin
      emit = 1'b1;
    end else if (s1_byte == hcfp_pkg::CHAR_NEWLINE) begin
      digit_count_next = '0;
    end else if (hv.ok) begin
      if (digit_count == hcfp_pkg::COUNT_W'(hcfp_pkg::FRAME_DIGITS - 1)) begin
        digit_count_next = '0;
        emit             = 1'b1;
        if (x_in && y_in) begin
          kind_next  = hcfp_pkg::KIND_ACCEPTED;
          pos_x_next = wx;
          pos_y_next = wy;
        end else begin
          kind_next = hcfp_pkg::KIND_OUT_OF_RANGE;
        end
      end else begin
        store_we         = 1'b1;
        digit_count_next = digit_count + 1'b1;
      end
    end
  end

  // Digit counter
  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count <= '0;
    end else if (s1_advance) begin
      digit_count <= digit_count_next;
    end
  end

  // Digit store, first seven digits of a frame
  always_ff @(posedge clk) begin
    if (s1_advance && store_we) begin
      digit_store[digit_count] <= hv.value;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && emit) begin
      pos_x <= pos_x_next;
      pos_y <= pos_y_next;
      kind  <= kind_next;
    end
  end

  assign frame_kind = kind;

  // Zeroed kinds carry a zero position
  a_zeroed_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != hcfp_pkg::KIND_ACCEPTED |-> pos_x == '0 && pos_y == '0)
    else $error("zeroed result with nonzero position");

  // Accepted positions respect the limit
  a_accept_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == hcfp_pkg::KIND_ACCEPTED |->
      signed'({pos_x[15], pos_x}) >= lim_neg && signed'({pos_x[15], pos_x}) <= lim_pos &&
      signed'({pos_y[15], pos_y}) >= lim_neg && signed'({pos_y[15], pos_y}) <= lim_pos)
    else $error("accepted position outside limit");

  // A stalled input register keeps its byte
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_advance |=> s1_valid && $stable(s1_byte))
    else $error("input register lost a stalled byte");

  // A stop result only leaves an empty frame
  a_stop_empty: assert property (@(posedge clk) disable iff (rst)
    s1_advance && emit && kind_next == hcfp_pkg::KIND_STOP |-> digit_count == '0)
    else $error("stop result with digits collected");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for hex_coordinate_frame_parser: drives bytes,
// predicts each position result and compares it field by field.
// Depends on hcfp_pkg and the hex_coordinate_frame_parser RTL.
module testbench;

  localparam logic [7:0]  CHAR_ZERO    = 8'h30;
  localparam logic [7:0]  CHAR_UPPER_A = 8'h41;
  localparam logic [7:0]  CHAR_LOWER_A = 8'h61;
  localparam logic [14:0] LIMIT_MAX    = 15'h7FFF;
  localparam logic [14:0] LIMIT_MIN    = 15'h0000;
  localparam int          IDLE_CYCLES  = 8;
  localparam int          HOLD_CYCLES  = 400;

  typedef struct packed {
    logic [15:0]           x;
    logic [15:0]           y;
    hcfp_pkg::frame_kind_t kind;
  } position_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [1:0]  frame_kind;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [14:0] position_limit;

  // Predicted parser state
  logic [3:0]  digit_buf [0:7];
  int          digit_cnt = 0;
  logic [15:0] held_x = '0;
  logic [15:0] held_y = '0;
  logic [14:0] limit_reg = hcfp_pkg::LIMIT_RESET;

  position_t   expected_positions[$];

  int err_count = 0;
  int n_bytes = 0;
  int n_checked = 0;
  int n_accepted = 0;
  int n_out_of_range = 0;
  int n_stops = 0;
  int n_limits = 0;
  int burst_left = 0;
  int hold_request = 0;
  int hold_left = 0;
  int pattern_mode = 0;
  int pattern_left = 0;

  hex_coordinate_frame_parser uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .frame_kind     (frame_kind),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .position_limit (position_limit)
  );

  initial forever #2 clk = ~clk;

  // Stop a hung run
  initial begin
    #1600000;
    $display("FAIL hex_coordinate_frame_parser");
    $finish;
  end

  // Decode an upper-case hex digit; returns 0 for any other byte
  function automatic bit hex_value(input logic [7:0] c, output logic [3:0] v);
    v = '0;
    if (c >= CHAR_ZERO && c < CHAR_ZERO + 8'd10) begin
      v = 4'(c - CHAR_ZERO);
      return 1'b1;
    end
    if (c >= CHAR_UPPER_A && c < CHAR_UPPER_A + 8'd6) begin
      v = 4'(c - CHAR_UPPER_A + 8'd10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? CHAR_ZERO + 8'(n) : CHAR_UPPER_A + 8'(n) - 8'd10;
  endfunction

  // Advance the predicted state by one byte; returns 1 when a result is due
  function automatic bit track_byte(input logic [7:0] c, output position_t r);
    logic [3:0]  v;
    logic [15:0] wx;
    logic [15:0] wy;
    int          sx;
    int          sy;
    int          lim;
    r = '0;
    if (digit_cnt == 0 && c == hcfp_pkg::CHAR_STOP) begin
      held_x = '0;
      held_y = '0;
      r = '{x: held_x, y: held_y, kind: hcfp_pkg::KIND_STOP};
      return 1'b1;
    end
    if (c == hcfp_pkg::CHAR_NEWLINE) begin
      digit_cnt = 0;
      return 1'b0;
    end
    if (!hex_value(c, v)) return 1'b0;
    digit_buf[digit_cnt] = v;
    digit_cnt++;
    if (digit_cnt < hcfp_pkg::FRAME_DIGITS) return 1'b0;
    digit_cnt = 0;
    wx  = {digit_buf[0], digit_buf[1], digit_buf[2], digit_buf[3]};
    wy  = {digit_buf[4], digit_buf[5], digit_buf[6], digit_buf[7]};
    sx  = int'($signed(wx));
    sy  = int'($signed(wy));
    lim = int'(limit_reg);
    if (sx >= -lim && sx <= lim && sy >= -lim && sy <= lim) begin
      held_x = wx;
      held_y = wy;
      r = '{x: held_x, y: held_y, kind: hcfp_pkg::KIND_ACCEPTED};
    end else begin
      held_x = '0;
      held_y = '0;
      r = '{x: held_x, y: held_y, kind: hcfp_pkg::KIND_OUT_OF_RANGE};
    end
    return 1'b1;
  endfunction

  // Pick a coordinate, weighted toward the current limit and its edges
  function automatic logic [15:0] pick_coord();
    int lim;
    int v;
    lim = int'(limit_reg);
    case ($urandom_range(0, 9))
      0: v = $urandom_range(0, 65535);
      1, 2, 3, 4: begin
        v = $urandom_range(0, 2 * lim);
        v = v - lim;
      end
      5: v = lim;
      6: v = -lim;
      7: v = lim + 1;
      8: v = -lim - 1;
      default: v = $urandom_range(0, 1) ? 32767 : -32768;
    endcase
    return v[15:0];
  endfunction

  // Pick a byte that is neither a digit nor a newline
  function automatic logic [7:0] random_noise(input bit allow_stop);
    logic [7:0] c;
    logic [3:0] v;
    if ($urandom_range(0, 3) == 0) return CHAR_LOWER_A + 8'($urandom_range(0, 5));
    do begin
      c = 8'($urandom_range(0, 255));
    end while (hex_value(c, v) || c == hcfp_pkg::CHAR_NEWLINE ||
               (!allow_stop && c == hcfp_pkg::CHAR_STOP));
    return c;
  endfunction

  // Offer one item in bursts with random gaps; predict at acceptance
  task automatic send_byte(input logic [7:0] c);
    position_t r;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    rx_byte  <= c;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    n_bytes++;
    if (track_byte(c, r)) expected_positions.push_back(r);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Send one eight-digit frame, optionally with ignored bytes mixed in
  task automatic send_frame(input logic [15:0] x, input logic [15:0] y, input bit noisy);
    logic [31:0] w;
    w = {x, y};
    for (int i = 0; i < 8; i++) begin
      if (noisy && $urandom_range(0, 2) == 0) send_byte(random_noise(i != 0));
      send_byte(hex_char(w[31 - 4 * i -: 4]));
    end
    if ($urandom_range(0, 3) == 0) send_byte(hcfp_pkg::CHAR_NEWLINE);
  endtask

  // Drop valid and wait until every result is in and the pipe has drained
  task automatic wait_idle();
    in_valid  <= 1'b0;
    burst_left = 0;
    while (expected_positions.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [14:0] v);
    wait_idle();
    cfg_valid      <= 1'b1;
    position_limit <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    limit_reg  = v;
    n_limits++;
  endtask

  // Mostly well-formed frames, plus stops, cut-off frames and noise
  task automatic send_random_items(input int n);
    int done;
    int pick;
    int len;
    done = 0;
    while (done < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        send_frame(pick_coord(), pick_coord(), $urandom_range(0, 3) == 0);
        done += 8;
      end else if (pick < 75) begin
        send_byte(hcfp_pkg::CHAR_STOP);
        done++;
      end else if (pick < 87) begin
        len = $urandom_range(1, 7);
        repeat (len) send_byte(hex_char(4'($urandom_range(0, 15))));
        send_byte(hcfp_pkg::CHAR_NEWLINE);
        done += len + 1;
      end else begin
        send_byte(random_noise(1'b1));
      end
    end
  endtask

  // Stop, empty newline, cut-off frame, stop and noise inside a frame,
  // the most negative value, and a frame right at the reset limit
  task automatic test_directed();
    send_byte(hcfp_pkg::CHAR_STOP);
    send_byte(hcfp_pkg::CHAR_NEWLINE);
    send_text("7F");
    send_byte(hcfp_pkg::CHAR_NEWLINE);
    send_text("8");
    send_byte(hcfp_pkg::CHAR_STOP);
    send_text("0");
    send_byte(8'h00);
    send_text("0");
    send_byte(CHAR_LOWER_A);
    send_text("0");
    send_byte(8'hFF);
    send_text("00FF");
    send_text("00FFFF01");
    wait_idle();
  endtask

  task automatic test_limit_extremes();
    write_limit(LIMIT_MIN);
    send_random_items(250);
    write_limit(LIMIT_MAX);
    send_frame(16'h8001, 16'h7FFF, 1'b0);
    send_frame(16'h7FFF, 16'h8000, 1'b0);
    send_random_items(250);
  endtask

  task automatic test_random_limits();
    repeat (4) begin
      write_limit(15'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 512)
                                                  : $urandom_range(0, 32767)));
      send_random_items(150);
    end
    write_limit(hcfp_pkg::LIMIT_RESET);
    send_random_items(100);
  endtask

  // Hold the receiver off so the block fills and stalls its input
  task automatic test_receiver_hold();
    in_valid  <= 1'b0;
    burst_left = 0;
    @(negedge clk) hold_request = HOLD_CYCLES;
    @(posedge clk);
    repeat (15) send_frame(pick_coord(), pick_coord(), 1'b0);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    send_random_items(200);
  endtask

  // Receiver: long hold when asked, else a stall pattern of its own
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        pattern_mode = $urandom_range(0, 3);
        pattern_left = $urandom_range(16, 128);
      end
      pattern_left--;
      case (pattern_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 7) != 0);
        default: out_ready <= pattern_left[2];
      endcase
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    position_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_positions.size() == 0) begin
        $display("%0t: result with none expected: pos_x %h pos_y %h kind %0d",
                 $time, pos_x, pos_y, frame_kind);
        err_count++;
      end else begin
        e = expected_positions.pop_front();
        n_checked++;
        case (e.kind)
          hcfp_pkg::KIND_ACCEPTED:     n_accepted++;
          hcfp_pkg::KIND_OUT_OF_RANGE: n_out_of_range++;
          default:                     n_stops++;
        endcase
        if (pos_x !== e.x) begin
          $display("%0t: pos_x expected %h actual %h", $time, e.x, pos_x);
          err_count++;
        end
        if (pos_y !== e.y) begin
          $display("%0t: pos_y expected %h actual %h", $time, e.y, pos_y);
          err_count++;
        end
        if (frame_kind !== e.kind) begin
          $display("%0t: frame_kind expected %0d actual %0d", $time, e.kind, frame_kind);
          err_count++;
        end
      end
    end
  end

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    rx_byte        = '0;
    out_ready      = 1'b0;
    cfg_valid      = 1'b0;
    position_limit = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_limit_extremes();
    test_random_limits();
    test_receiver_hold();
    test_random_traffic();
    wait_idle();

    $display("Sent %0d bytes across %0d limit settings; checked %0d results:",
             n_bytes, n_limits, n_checked);
    $display("  %0d accepted, %0d out of range, %0d stop commands",
             n_accepted, n_out_of_range, n_stops);
    if (err_count == 0 && expected_positions.size() == 0) begin
      $display("PASS hex_coordinate_frame_parser");
    end else begin
      $display("FAIL hex_coordinate_frame_parser");
    end
    $finish;
  end

endmodule

FILE: hex_coordinate_frame_parser.f
src/hcfp_pkg.sv
src/hex_coordinate_frame_parser.sv
tb/testbench.sv
